### src/tbms_pkg.sv
// Package for the three-button mode selector and LED drive unit.
// Holds codes, constants, shared types and the image rebuild functions.
// No dependencies; the modules and the testbench use it by scoped names.
package tbms_pkg;

   // Request function codes
   localparam logic [1:0] FUNC_POLL  = 2'd0;
   localparam logic [1:0] FUNC_PRESS = 2'd1;
   localparam logic [1:0] FUNC_SET   = 2'd2;
   localparam logic [1:0] FUNC_IDLE  = 2'd3;   // unused function code, no effect

   // Button group indexes
   localparam int         NUM_GROUPS = 3;
   localparam logic [1:0] GRP_PAD    = 2'd0;
   localparam logic [1:0] GRP_HPF    = 2'd1;
   localparam logic [1:0] GRP_POL    = 2'd2;
   localparam logic [1:0] GRP_NONE   = 2'd3;   // no group: image rebuild only

   // Mode codes; the last one leaves a group's image bits alone
   localparam logic [1:0] MODE_FIRST  = 2'd0;
   localparam logic [1:0] MODE_SECOND = 2'd1;
   localparam logic [1:0] MODE_THIRD  = 2'd2;
   localparam logic [1:0] MODE_HOLD   = 2'd3;

   // Expander command bytes and fixed data
   localparam logic [2:0] REG_PORT0    = 3'd2;
   localparam logic [2:0] REG_PORT1    = 3'd3;
   localparam logic [7:0] PORT0_OFF    = 8'hFF;
   localparam logic [7:0] PORT1_OFF    = 8'h01;
   localparam logic [7:0] PORT1_INVERT = 8'h01;

   // Reset value of the debounce limit register
   localparam logic [3:0] DEBOUNCE_RESET = 4'd5;

   // Default depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   typedef logic [NUM_GROUPS-1:0][1:0] mode_arr_type;
   typedef logic [NUM_GROUPS-1:0][3:0] count_arr_type;

   // One queued image update: four expander writes
   typedef struct packed {
      logic [15:0] image;
      logic        last;
   } entry_type;

   // Queue transfer: push from the front, head view to the back
   typedef struct packed {
      logic      valid;
      entry_type entry;
   } xfer_type;

   // Write sequence steps of the back end
   typedef enum logic [3:0] {
      BEAT_OFF0  = 4'b0001,
      BEAT_OFF1  = 4'b0010,
      BEAT_PORT0 = 4'b0100,
      BEAT_PORT1 = 4'b1000
   } beat_type;

   // Image bits owned by a group
   function automatic logic [15:0] group_mask(input logic [1:0] g);
      logic [15:0] m;
      unique case (g)
         GRP_PAD: m = 16'h1807;
         GRP_HPF: m = 16'h0638;
         default: m = 16'h61C0;
      endcase
      return m;
   endfunction

   // Image bits set for a group in a given mode (LED and MOSFET)
   function automatic logic [15:0] group_bits(input logic [1:0] g, input logic [1:0] m);
      logic [15:0] b;
      b = 16'h0000;
      case (g)
         GRP_PAD: begin
            case (m)
               MODE_FIRST:  b = 16'h0801;
               MODE_SECOND: b = 16'h0002;
               default:     b = 16'h1004;
            endcase
         end
         GRP_HPF: begin
            case (m)
               MODE_FIRST:  b = 16'h0208;
               MODE_SECOND: b = 16'h0010;
               default:     b = 16'h0420;
            endcase
         end
         default: begin
            case (m)
               MODE_FIRST:  b = 16'h2040;
               MODE_SECOND: b = 16'h0080;
               default:     b = 16'h4100;
            endcase
         end
      endcase
      return b;
   endfunction

   // Rebuild the drive image from the group modes
   function automatic logic [15:0] rebuild_image(input logic [15:0] img,
                                                 input mode_arr_type modes);
      logic [15:0] r;
      r = img;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         if (modes[g] != MODE_HOLD) begin
            r = (r & ~group_mask(2'(g))) | group_bits(2'(g), modes[g]);
         end
      end
      return r;
   endfunction

   // Press step of the three-way counter; a held mode steps to the second
   function automatic logic [1:0] mode_step(input logic [1:0] m);
      logic [1:0] r;
      unique case (m)
         MODE_FIRST:  r = MODE_SECOND;
         MODE_SECOND: r = MODE_THIRD;
         MODE_THIRD:  r = MODE_FIRST;
         default:     r = MODE_SECOND;
      endcase
      return r;
   endfunction

endpackage

### src/tbms_req_if.sv
// Request channel interface: valid/ready plus one input transaction.
// Depends on nothing.
interface tbms_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic       pin_pol;
   logic       pin_hpf;
   logic       pin_pad;
   logic [1:0] button;
   logic [1:0] mode_value;

   modport source (output valid, func, pin_pol, pin_hpf, pin_pad, button, mode_value,
                   input ready);
   modport sink (input valid, func, pin_pol, pin_hpf, pin_pad, button, mode_value,
                 output ready);
endinterface

### src/tbms_rsp_if.sv
// Response channel interface: valid/ready plus one expander write transaction.
// Depends on nothing.
interface tbms_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] reg_index;
   logic [7:0] write_data;
   logic       last_write;

   modport source (output valid, reg_index, write_data, last_write, input ready);
   modport sink (input valid, reg_index, write_data, last_write, output ready);
endinterface

### src/three_button_mode_selector_led_drive_unit.sv
// Three-button mode selector with LED/MOSFET drive: top level.
// Depends on tbms_pkg, tbms_req_if, tbms_rsp_if, tbms_front, tbms_queue, tbms_back.
//
// Each request transaction is a poll of the three active-low buttons, a press
// event or a direct mode setting. Every mode change rebuilds the 16-bit drive
// image and produces four expander write transactions on rsp (port 0 off,
// port 1 off, port 0 image, port 1 image), so a transaction yields 0, 4, 8 or
// 12 writes, the final one flagged by last_write. The front end pushes one image
// update per mode change while the queue has room, and the back end issues one
// write per cycle while rsp is ready, so throughput is set by the write sequencer
// in the back end. A queue of QUEUE_DEPTH image updates lets the front keep
// accepting while writes are still draining. The debounce limit is written through
// csr_we/csr_wdata; the user must write it only while the block is idle, and the
// block itself does not enforce this. It resets to 5.
module three_button_mode_selector_led_drive_unit #(
   parameter int QUEUE_DEPTH = tbms_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   tbms_req_if.sink    req,
   tbms_rsp_if.source  rsp,
   input  logic        csr_we,
   input  logic [3:0]  csr_wdata
);

   tbms_pkg::xfer_type push;
   tbms_pkg::xfer_type head;
   logic               q_full;
   logic               pop;

   // Classify transactions and update mode state
   tbms_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .q_full    (q_full),
      .push      (push)
   );

   // Image update queue
   tbms_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (q_full),
      .head  (head),
      .pop   (pop)
   );

   // Expander write sequencer
   tbms_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp)
   );

endmodule

### src/tbms_front.sv
// Front end: accepts request transactions, debounces, steps group modes
// and pushes one image update per mode change. Depends on tbms_pkg, tbms_req_if.
module tbms_front (
   input  logic                clock,
   input  logic                reset,
   tbms_req_if.sink            req,
   input  logic                csr_we,
   input  logic [3:0]          csr_wdata,
   input  logic                q_full,
   output tbms_pkg::xfer_type  push
);

   logic [3:0]              limit_ff, limit_in;
   logic [2:0]              level_ff, level_in;
   tbms_pkg::count_arr_type count_ff, count_in;
   tbms_pkg::mode_arr_type  modes_ff, modes_in;
   logic [15:0]             image_ff, image_in;

   // Pending work for the accepted transaction
   logic       pend_valid_ff, pend_valid_in;
   logic [1:0] pend_func_ff, pend_func_in;
   logic [2:0] pend_fire_ff, pend_fire_in;
   logic [1:0] pend_btn_ff, pend_btn_in;
   logic [1:0] pend_mode_ff, pend_mode_in;

   logic       accept;
   logic       step;
   logic       step_last;
   logic [2:0] pins;
   logic [2:0] fire;
   logic [1:0] sel;
   logic [2:0] remain;
   tbms_pkg::mode_arr_type step_modes;

   // Debounce limit register
   always_comb begin
      limit_in = csr_we ? csr_wdata : limit_ff;
   end

   assign pins   = {req.pin_pol, req.pin_hpf, req.pin_pad};
   assign accept = req.valid && req.ready;

   // Debounce all three buttons on a poll
   always_comb begin
      level_in = level_ff;
      count_in = count_ff;
      fire     = 3'b000;
      if (accept && (req.func == tbms_pkg::FUNC_POLL)) begin
         for (int g = 0; g < tbms_pkg::NUM_GROUPS; g++) begin
            if (level_ff[g] && !pins[g]) begin
               if (count_ff[g] < limit_ff) begin
                  count_in[g] = count_ff[g] + 4'd1;
               end else begin
                  fire[g]     = 1'b1;
                  level_in[g] = 1'b0;
               end
            end else begin
               count_in[g] = 4'd0;
               level_in[g] = pins[g];
            end
         end
      end
   end

   // Pick the next group to fire: pol, then hpf, then pad
   always_comb begin
      if (pend_fire_ff[tbms_pkg::GRP_POL]) begin
         sel = tbms_pkg::GRP_POL;
      end else if (pend_fire_ff[tbms_pkg::GRP_HPF]) begin
         sel = tbms_pkg::GRP_HPF;
      end else begin
         sel = tbms_pkg::GRP_PAD;
      end
      remain      = pend_fire_ff;
      remain[sel] = 1'b0;
   end

   // One mode update per cycle while the queue has room
   assign step = pend_valid_ff && !q_full;

   always_comb begin
      step_modes = modes_ff;
      step_last  = 1'b1;
      unique case (pend_func_ff)
         tbms_pkg::FUNC_POLL: begin
            step_modes[sel] = tbms_pkg::mode_step(modes_ff[sel]);
            step_last       = (remain == 3'b000);
         end
         tbms_pkg::FUNC_PRESS: begin
            if (pend_btn_ff != tbms_pkg::GRP_NONE) begin
               step_modes[pend_btn_ff] = tbms_pkg::mode_step(modes_ff[pend_btn_ff]);
            end
         end
         default: begin
            if (pend_btn_ff != tbms_pkg::GRP_NONE) begin
               step_modes[pend_btn_ff] = pend_mode_ff;
            end
         end
      endcase
   end

   always_comb begin
      modes_in = step ? step_modes : modes_ff;
      image_in = step ? tbms_pkg::rebuild_image(image_ff, step_modes) : image_ff;
   end

   always_comb begin
      push.valid       = step;
      push.entry.image = tbms_pkg::rebuild_image(image_ff, step_modes);
      push.entry.last  = step_last;
   end

   // Take a new transaction once the pending one finishes
   assign req.ready = !pend_valid_ff || (step && step_last);

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_func_in  = pend_func_ff;
      pend_fire_in  = pend_fire_ff;
      pend_btn_in   = pend_btn_ff;
      pend_mode_in  = pend_mode_ff;
      if (step) begin
         pend_fire_in = remain;
         if (step_last) begin
            pend_valid_in = 1'b0;
         end
      end
      if (accept) begin
         pend_func_in = req.func;
         pend_fire_in = fire;
         pend_btn_in  = req.button;
         pend_mode_in = req.mode_value;
         case (req.func) inside
            tbms_pkg::FUNC_POLL:                     pend_valid_in = (fire != 3'b000);
            tbms_pkg::FUNC_PRESS, tbms_pkg::FUNC_SET: pend_valid_in = 1'b1;
            default:                                 pend_valid_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff      <= tbms_pkg::DEBOUNCE_RESET;
         level_ff      <= 3'b111;
         count_ff      <= '0;
         modes_ff      <= '0;
         image_ff      <= 16'h0000;
         pend_valid_ff <= 1'b0;
      end else begin
         limit_ff      <= limit_in;
         level_ff      <= level_in;
         count_ff      <= count_in;
         modes_ff      <= modes_in;
         image_ff      <= image_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   // Pending payload
   always_ff @(posedge clock) begin
      pend_func_ff <= pend_func_in;
      pend_fire_ff <= pend_fire_in;
      pend_btn_ff  <= pend_btn_in;
      pend_mode_ff <= pend_mode_in;
   end

endmodule

### src/tbms_queue.sv
// Short FIFO of image updates between the front and back ends.
// Depends on tbms_pkg.
module tbms_queue #(
   parameter int DEPTH = tbms_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  tbms_pkg::xfer_type  push,
   output logic                full,
   output tbms_pkg::xfer_type  head,
   input  logic                pop
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   tbms_pkg::entry_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full       = (count_ff == CW'(DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.entry = mem_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push.valid && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push.valid) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule

### src/tbms_back.sv
// Back end: turns each queued image into four expander write transactions.
// Depends on tbms_pkg, tbms_rsp_if.
module tbms_back (
   input  logic                clock,
   input  logic                reset,
   input  tbms_pkg::xfer_type  head,
   output logic                pop,
   tbms_rsp_if.source          rsp
);

   tbms_pkg::beat_type beat_ff, beat_in;
   logic       valid_ff, valid_in;
   logic [2:0] reg_ff, reg_in;
   logic [7:0] data_ff, data_in;
   logic       last_ff, last_in;
   logic       load;

   // Load the output register when it is empty or being drained
   assign load = head.valid && (!valid_ff || rsp.ready);
   assign pop  = load && (beat_ff == tbms_pkg::BEAT_PORT1);

   // Write sequence decode
   always_comb begin
      last_in = 1'b0;
      unique case (beat_ff)
         tbms_pkg::BEAT_OFF0: begin
            reg_in  = tbms_pkg::REG_PORT0;
            data_in = tbms_pkg::PORT0_OFF;
            beat_in = tbms_pkg::BEAT_OFF1;
         end
         tbms_pkg::BEAT_OFF1: begin
            reg_in  = tbms_pkg::REG_PORT1;
            data_in = tbms_pkg::PORT1_OFF;
            beat_in = tbms_pkg::BEAT_PORT0;
         end
         tbms_pkg::BEAT_PORT0: begin
            reg_in  = tbms_pkg::REG_PORT0;
            data_in = ~head.entry.image[7:0];
            beat_in = tbms_pkg::BEAT_PORT1;
         end
         default: begin
            reg_in  = tbms_pkg::REG_PORT1;
            data_in = head.entry.image[15:8] ^ tbms_pkg::PORT1_INVERT;
            beat_in = tbms_pkg::BEAT_OFF0;
            last_in = head.entry.last;
         end
      endcase
   end

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff  <= tbms_pkg::BEAT_OFF0;
         valid_ff <= 1'b0;
      end else begin
         if (load) begin
            beat_ff <= beat_in;
         end
         valid_ff <= valid_in;
      end
   end

   // Output payload
   always_ff @(posedge clock) begin
      if (load) begin
         reg_ff  <= reg_in;
         data_ff <= data_in;
         last_ff <= last_in;
      end
   end

   assign rsp.valid      = valid_ff;
   assign rsp.reg_index  = reg_ff;
   assign rsp.write_data = data_ff;
   assign rsp.last_write = last_ff;

endmodule

### tb/sv/three_button_mode_selector_led_drive_unit_test.sv
// Self-checking testbench for the three-button mode selector LED drive unit.
// Depends on tbms_pkg, tbms_req_if, tbms_rsp_if and the unit's top level;
// writes are checked against a cycle-free predictor of the expander traffic.
`timescale 1ns / 1ps

module three_button_mode_selector_led_drive_unit_test;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 16;
   localparam int SEG_ITEMS    = 54;
   localparam int N_SEGMENTS   = 6;
   localparam int N_DIRECTED   = 25;

   // Debounce limit for each random segment, extremes first
   localparam logic [N_SEGMENTS-1:0][3:0] SEG_LIMITS =
      {tbms_pkg::DEBOUNCE_RESET, 4'd9, 4'd2, 4'd1, 4'd15, 4'd0};

   // Image bits owned by each group, and the bits set per group and mode
   localparam logic [2:0][15:0] GROUP_MASK = {16'h61C0, 16'h0638, 16'h1807};
   localparam logic [2:0][2:0][15:0] GROUP_BITS = {
      {16'h4100, 16'h0080, 16'h2040},
      {16'h0420, 16'h0010, 16'h0208},
      {16'h1004, 16'h0002, 16'h0801}};

   typedef struct packed {
      logic [2:0] reg_index;
      logic [7:0] write_data;
      logic       last_write;
   } expander_write_type;

   typedef struct packed {
      logic [1:0] func;
      logic       pin_pol;
      logic       pin_hpf;
      logic       pin_pad;
      logic [1:0] button;
      logic [1:0] mode_value;
   } req_item_type;

   // One directed row; port data is typed in only where fixed is set
   typedef struct packed {
      req_item_type item;
      logic         fixed;
      logic [3:0]   n_writes;
      logic [7:0]   port0;
      logic [7:0]   port1;
   } directed_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_we = 1'b0;
   logic [3:0] csr_wdata = 4'd0;

   tbms_req_if req ();
   tbms_rsp_if rsp ();

   three_button_mode_selector_led_drive_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // Predictor state
   logic [3:0]      limit_q;
   logic [2:0]      level_q;
   logic [2:0][3:0] count_q;
   logic [2:0][1:0] mode_q;
   logic [15:0]     image_q;

   expander_write_type new_writes [$];      // writes of the transaction just taken
   expander_write_type pending_writes [$];  // writes still owed by the unit

   int          error_count = 0;
   int unsigned cycle_count = 0;
   int          src_idle_pct = 0;
   int          snk_idle_pct = 0;
   int          held_left [3];

   directed_row_type directed_rows [N_DIRECTED] = '{
      '{'{tbms_pkg::FUNC_IDLE, 1'b0, 1'b0, 1'b0, tbms_pkg::GRP_NONE, tbms_pkg::MODE_HOLD},
        1'b1, 4'd0, 8'h00, 8'h00},
      '{'{tbms_pkg::FUNC_POLL, 1'b1, 1'b1, 1'b1, tbms_pkg::GRP_PAD, tbms_pkg::MODE_FIRST},
        1'b1, 4'd0, 8'h00, 8'h00},
      // button three still rebuilds from the reset modes
      '{'{tbms_pkg::FUNC_PRESS, 1'b1, 1'b1, 1'b1, tbms_pkg::GRP_NONE, tbms_pkg::MODE_FIRST},
        1'b1, 4'd4, 8'hB6, 8'h2B},
      '{'{tbms_pkg::FUNC_SET, 1'b0, 1'b0, 1'b0, tbms_pkg::GRP_PAD, tbms_pkg::MODE_HOLD},
        1'b1, 4'd4, 8'hB6, 8'h2B},
      // pad held mode steps to the second mode, then wraps round
      '{'{tbms_pkg::FUNC_PRESS, 1'b0, 1'b0, 1'b0, tbms_pkg::GRP_PAD, tbms_pkg::MODE_FIRST},
        1'b0, 4'd0, 8'h00, 8'h00},
      '{'{tbms_pkg::FUNC_PRESS, 1'b0, 1'b0, 1'b0, tbms_pkg::GRP_PAD, tbms_pkg::MODE_FIRST},
        1'b0, 4'd0, 8'h00, 8'h00},
      '{'{tbms_pkg::FUNC_PRESS, 1'b0, 1'b0, 1'b0, tbms_pkg::GRP_PAD, tbms_pkg::MODE_FIRST},
        1'b0, 4'd0, 8'h00, 8'h00},
      '{'{tbms_pkg::FUNC_SET, 1'b1, 1'b0, 1'b1, tbms_pkg::GRP_HPF, tbms_pkg::MODE_THIRD},
        1'b0, 4'd0, 8'h00, 8'h00},
      '{'{tbms_pkg::FUNC_SET, 1'b0, 1'b1, 1'b0, tbms_pkg::GRP_POL, tbms_pkg::MODE_SECOND},
        1'b0, 4'd0, 8'h00, 8'h00},
      '{'{tbms_pkg::FUNC_SET, 1'b1, 1'b1, 1'b1, tbms_pkg::GRP_NONE, tbms_pkg::MODE_FIRST},
        1'b0, 4'd0, 8'h00, 8'h00},
      '{'{tbms_pkg::FUNC_PRESS, 1'b0, 1'b0, 1'b0, tbms_pkg::GRP_HPF, tbms_pkg::MODE_HOLD},
        1'b0, 4'd0, 8'h00, 8'h00},
      '{'{tbms_pkg::FUNC_PRESS, 1'b0, 1'b0, 1'b0, tbms_pkg::GRP_POL, tbms_pkg::MODE_HOLD},
        1'b0, 4'd0, 8'h00, 8'h00},
      // all three held low: the sixth poll fires every group at once
      '{'{tbms_pkg::FUNC_POLL, 1'b0, 1'b0, 1'b0, tbms_pkg::GRP_PAD, tbms_pkg::MODE_FIRST},
        1'b0, 4'd0, 8'h00, 8'h00},
      '{'{tbms_pkg::FUNC_POLL, 1'b0, 1'b0, 1'b0, tbms_pkg::GRP_PAD, tbms_pkg::MODE_FIRST},
        1'b0, 4'd0, 8'h00, 8'h00},
      '{'{tbms_pkg::FUNC_POLL, 1'b0, 1'b0, 1'b0, tbms_pkg::GRP_PAD, tbms_pkg::MODE_FIRST},
        1'b0, 4'd0, 8'h00, 8'h00},
      '{'{tbms_pkg::FUNC_POLL, 1'b0, 1'b0, 1'b0, tbms_pkg::GRP_PAD, tbms_pkg::MODE_FIRST},
        1'b0, 4'd0, 8'h00, 8'h00},
      '{'{tbms_pkg::FUNC_POLL, 1'b0, 1'b0, 1'b0, tbms_pkg::GRP_PAD, tbms_pkg::MODE_FIRST},
        1'b0, 4'd0, 8'h00, 8'h00},
      '{'{tbms_pkg::FUNC_POLL, 1'b0, 1'b0, 1'b0, tbms_pkg::GRP_PAD, tbms_pkg::MODE_FIRST},
        1'b0, 4'd0, 8'h00, 8'h00},
      '{'{tbms_pkg::FUNC_POLL, 1'b0, 1'b0, 1'b0, tbms_pkg::GRP_POL, tbms_pkg::MODE_HOLD},
        1'b0, 4'd0, 8'h00, 8'h00},
      '{'{tbms_pkg::FUNC_POLL, 1'b1, 1'b1, 1'b1, tbms_pkg::GRP_NONE, tbms_pkg::MODE_HOLD},
        1'b0, 4'd0, 8'h00, 8'h00},
      '{'{tbms_pkg::FUNC_POLL, 1'b0, 1'b1, 1'b1, tbms_pkg::GRP_HPF, tbms_pkg::MODE_SECOND},
        1'b0, 4'd0, 8'h00, 8'h00},
      '{'{tbms_pkg::FUNC_SET, 1'b0, 1'b0, 1'b0, tbms_pkg::GRP_POL, tbms_pkg::MODE_HOLD},
        1'b0, 4'd0, 8'h00, 8'h00},
      '{'{tbms_pkg::FUNC_SET, 1'b1, 1'b1, 1'b1, tbms_pkg::GRP_HPF, tbms_pkg::MODE_HOLD},
        1'b0, 4'd0, 8'h00, 8'h00},
      '{'{tbms_pkg::FUNC_PRESS, 1'b1, 1'b1, 1'b1, tbms_pkg::GRP_POL, tbms_pkg::MODE_THIRD},
        1'b0, 4'd0, 8'h00, 8'h00},
      '{'{tbms_pkg::FUNC_IDLE, 1'b1, 1'b1, 1'b1, tbms_pkg::GRP_NONE, tbms_pkg::MODE_HOLD},
        1'b1, 4'd0, 8'h00, 8'h00}
   };

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("MISMATCH cycle %0d: %s", cycle_count, msg);
   endtask

   // Rebuild the drive image and queue its four expander writes
   task automatic rebuild_image_writes();
      expander_write_type w;
      for (int g = 0; g < tbms_pkg::NUM_GROUPS; g++) begin
         if (mode_q[g] != tbms_pkg::MODE_HOLD) begin
            image_q = (image_q & ~GROUP_MASK[g]) | GROUP_BITS[g][mode_q[g]];
         end
      end
      w = {tbms_pkg::REG_PORT0, tbms_pkg::PORT0_OFF, 1'b0};
      new_writes.push_back(w);
      w = {tbms_pkg::REG_PORT1, tbms_pkg::PORT1_OFF, 1'b0};
      new_writes.push_back(w);
      w = {tbms_pkg::REG_PORT0, ~image_q[7:0], 1'b0};
      new_writes.push_back(w);
      w = {tbms_pkg::REG_PORT1, image_q[15:8] ^ tbms_pkg::PORT1_INVERT, 1'b0};
      new_writes.push_back(w);
   endtask

   // Three-way step; a held mode goes to the second mode
   task automatic step_group(input logic [1:0] g);
      if (g != tbms_pkg::GRP_NONE) begin
         case (mode_q[g])
            tbms_pkg::MODE_FIRST:  mode_q[g] = tbms_pkg::MODE_SECOND;
            tbms_pkg::MODE_SECOND: mode_q[g] = tbms_pkg::MODE_THIRD;
            tbms_pkg::MODE_THIRD:  mode_q[g] = tbms_pkg::MODE_FIRST;
            default:               mode_q[g] = tbms_pkg::MODE_SECOND;
         endcase
      end
      rebuild_image_writes();
   endtask

   task automatic debounce_button(input logic [1:0] g, input logic pin);
      if (level_q[g] && !pin) begin
         if (count_q[g] < limit_q) begin
            count_q[g] = count_q[g] + 4'd1;
         end else begin
            step_group(g);
            level_q[g] = 1'b0;
         end
      end else begin
         count_q[g] = 4'd0;
         level_q[g] = pin;
      end
   endtask

   // Expected expander writes for one accepted request
   task automatic predict_writes(input req_item_type it);
      new_writes.delete();
      case (it.func)
         tbms_pkg::FUNC_POLL: begin
            debounce_button(tbms_pkg::GRP_POL, it.pin_pol);
            debounce_button(tbms_pkg::GRP_HPF, it.pin_hpf);
            debounce_button(tbms_pkg::GRP_PAD, it.pin_pad);
         end
         tbms_pkg::FUNC_PRESS: begin
            step_group(it.button);
         end
         tbms_pkg::FUNC_SET: begin
            if (it.button != tbms_pkg::GRP_NONE) mode_q[it.button] = it.mode_value;
            rebuild_image_writes();
         end
         default: ;
      endcase
      if (new_writes.size() > 0) new_writes[new_writes.size()-1].last_write = 1'b1;
   endtask

   // Present one request and wait for it to be taken
   task automatic send_request(input req_item_type it);
      while ($urandom_range(0, 99) < src_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid      <= 1'b1;
      req.func       <= it.func;
      req.pin_pol    <= it.pin_pol;
      req.pin_hpf    <= it.pin_hpf;
      req.pin_pad    <= it.pin_pad;
      req.button     <= it.button;
      req.mode_value <= it.mode_value;
      do @(posedge clock); while (!req.ready);
   endtask

   // Send, then queue either the predicted or the typed-in writes
   task automatic issue_request(input directed_row_type row);
      expander_write_type w;
      send_request(row.item);
      predict_writes(row.item);
      if (row.fixed) begin
         if (row.n_writes != 4'd0) begin
            w = {tbms_pkg::REG_PORT0, tbms_pkg::PORT0_OFF, 1'b0};
            pending_writes.push_back(w);
            w = {tbms_pkg::REG_PORT1, tbms_pkg::PORT1_OFF, 1'b0};
            pending_writes.push_back(w);
            w = {tbms_pkg::REG_PORT0, row.port0, 1'b0};
            pending_writes.push_back(w);
            w = {tbms_pkg::REG_PORT1, row.port1, 1'b1};
            pending_writes.push_back(w);
         end
      end else begin
         foreach (new_writes[i]) pending_writes.push_back(new_writes[i]);
      end
   endtask

   // Register write only once the unit has drained
   task automatic set_debounce_limit(input logic [3:0] value);
      req.valid <= 1'b0;
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      limit_q = value;
   endtask

   // Mostly well-formed button holds with random length, some noise
   task automatic make_random_request(output req_item_type it);
      int         pick;
      logic [2:0] pins;
      pick = $urandom_range(0, 99);
      it = $bits(req_item_type)'($urandom);
      if (pick < 70) begin
         it.func = tbms_pkg::FUNC_POLL;
         for (int g = 0; g < tbms_pkg::NUM_GROUPS; g++) begin
            if (held_left[g] > 0) begin
               pins[g] = 1'b0;
               held_left[g]--;
            end else if ($urandom_range(0, 99) < 15) begin
               held_left[g] = $urandom_range(0, limit_q + 3);
               pins[g] = 1'b0;
            end else begin
               pins[g] = 1'b1;
            end
            if ($urandom_range(0, 99) < 4) pins[g] = ~pins[g];
         end
         it.pin_pol = pins[tbms_pkg::GRP_POL];
         it.pin_hpf = pins[tbms_pkg::GRP_HPF];
         it.pin_pad = pins[tbms_pkg::GRP_PAD];
      end else if (pick < 85) begin
         it.func = tbms_pkg::FUNC_PRESS;
      end else if (pick < 97) begin
         it.func = tbms_pkg::FUNC_SET;
      end else begin
         it.func = tbms_pkg::FUNC_IDLE;
      end
   endtask

   // Result side: check each write transaction, then pick next ready
   always @(posedge clock) begin : write_checker
      expander_write_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_writes.size() == 0) begin
            report_mismatch($sformatf("unexpected write reg %0d data %02h",
                                      rsp.reg_index, rsp.write_data));
         end else begin
            want = pending_writes.pop_front();
            if (rsp.reg_index !== want.reg_index)
               report_mismatch($sformatf("reg_index %0d, want %0d",
                                         rsp.reg_index, want.reg_index));
            if (rsp.write_data !== want.write_data)
               report_mismatch($sformatf("write_data %02h, want %02h",
                                         rsp.write_data, want.write_data));
            if (rsp.last_write !== want.last_write)
               report_mismatch($sformatf("last_write %0b, want %0b",
                                         rsp.last_write, want.last_write));
         end
      end
      rsp.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
   end

   // Run watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin : stimulus
      directed_row_type row;
      int               counted;

      req.valid      = 1'b0;
      req.func       = tbms_pkg::FUNC_POLL;
      req.pin_pol    = 1'b1;
      req.pin_hpf    = 1'b1;
      req.pin_pad    = 1'b1;
      req.button     = tbms_pkg::GRP_PAD;
      req.mode_value = tbms_pkg::MODE_FIRST;
      rsp.ready      = 1'b0;

      // Predictor reset state
      limit_q = tbms_pkg::DEBOUNCE_RESET;
      level_q = '1;
      count_q = '0;
      mode_q  = '0;
      image_q = '0;
      foreach (held_left[g]) held_left[g] = 0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed table, from reset state
      src_idle_pct = 28;
      snk_idle_pct = 58;
      for (int r = 0; r < N_DIRECTED; r++) begin
         issue_request(directed_rows[r]);
      end

      // Random segments: receiver-heavy idling, sender-heavy, then none
      row = '0;
      for (int s = 0; s < N_SEGMENTS; s++) begin
         src_idle_pct = (s < 2) ? 28 : (s < 4) ? 58 : 0;
         snk_idle_pct = (s < 2) ? 58 : (s < 4) ? 28 : 0;
         set_debounce_limit(SEG_LIMITS[s]);
         foreach (held_left[g]) held_left[g] = 0;
         counted = 0;
         while (counted < SEG_ITEMS) begin
            make_random_request(row.item);
            issue_request(row);
            counted++;
         end
      end

      // Drain and finish
      req.valid <= 1'b0;
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

### three_button_mode_selector_led_drive_unit.f
src/tbms_pkg.sv
src/tbms_req_if.sv
src/tbms_rsp_if.sv
src/tbms_front.sv
src/tbms_queue.sv
src/tbms_back.sv
src/three_button_mode_selector_led_drive_unit.sv
tb/sv/three_button_mode_selector_led_drive_unit_test.sv
